>>> rtl/core/stok_pkg.sv
// Shared types, token codes and helper functions for the source tokenizer.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package stok_pkg;

    localparam int POSITION_BITS = 24;
    localparam logic [63:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef logic [POSITION_BITS-1:0] pos_t;

    // Token kind codes.
    localparam logic [5:0] K_NUMBER    = 6'd0;
    localparam logic [5:0] K_ID        = 6'd1;
    localparam logic [5:0] K_STRING    = 6'd2;
    localparam logic [5:0] K_LPAREN    = 6'd3;
    localparam logic [5:0] K_RPAREN    = 6'd4;
    localparam logic [5:0] K_LBRACE    = 6'd5;
    localparam logic [5:0] K_RBRACE    = 6'd6;
    localparam logic [5:0] K_LBRACKET  = 6'd7;
    localparam logic [5:0] K_RBRACKET  = 6'd8;
    localparam logic [5:0] K_COMMA     = 6'd9;
    localparam logic [5:0] K_PLUS      = 6'd10;
    localparam logic [5:0] K_INCREASE  = 6'd11;
    localparam logic [5:0] K_MINUS     = 6'd12;
    localparam logic [5:0] K_DECREASE  = 6'd13;
    localparam logic [5:0] K_ARROW     = 6'd14;
    localparam logic [5:0] K_MULTIPLY  = 6'd15;
    localparam logic [5:0] K_DIVIDE    = 6'd16;
    localparam logic [5:0] K_MODULO    = 6'd17;
    localparam logic [5:0] K_ASSIGN    = 6'd18;
    localparam logic [5:0] K_EQUALS    = 6'd19;
    localparam logic [5:0] K_NOT       = 6'd20;
    localparam logic [5:0] K_NOT_EQ    = 6'd21;
    localparam logic [5:0] K_LESS      = 6'd22;
    localparam logic [5:0] K_LESS_EQ   = 6'd23;
    localparam logic [5:0] K_SHL       = 6'd24;
    localparam logic [5:0] K_MORE      = 6'd25;
    localparam logic [5:0] K_MORE_EQ   = 6'd26;
    localparam logic [5:0] K_SHR       = 6'd27;
    localparam logic [5:0] K_AND       = 6'd28;
    localparam logic [5:0] K_OR        = 6'd29;
    localparam logic [5:0] K_XOR       = 6'd30;
    localparam logic [5:0] K_BIT_NOT   = 6'd31;
    localparam logic [5:0] K_EOL       = 6'd32;
    localparam logic [5:0] K_RANGE_DOT = 6'd33;
    localparam logic [5:0] K_EOF       = 6'd34;
    localparam logic [5:0] K_TEXT      = 6'd35;
    localparam logic [5:0] K_ILLEGAL   = 6'd36;
    localparam logic [5:0] K_QUOTE     = 6'd37;
    localparam logic [5:0] K_LONE_DOT  = 6'd38;

    // Scan modes.
    typedef enum logic [4:0] {
        M_IDLE, M_IDENT, M_NZERO, M_NUM, M_CH_OPEN, M_CH_ESC, M_CH_CLOSE,
        M_STR, M_STR_ESC, M_LCOMM, M_BCOMM, M_BSTAR, M_DOT,
        M_PLUS, M_EQ, M_OR, M_AND, M_GT, M_LT, M_BANG, M_MINUS, M_SLASH
    } mode_t;

    typedef enum logic [1:0] {B_DEC, B_HEX, B_BIN} base_t;

    // One result token.
    typedef struct packed {
        logic [5:0]  kind;
        pos_t        pos;
        logic [63:0] value;
        logic [7:0]  text_char;
    } token_t;

    // Up to two results for one input transfer.
    typedef struct packed {
        logic   valid0;
        logic   valid1;
        token_t tok0;
        token_t tok1;
    } result_pair_t;

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            "n": r = 8'd10;
            "r": r = 8'd13;
            "t": r = 8'd9;
            "b": r = 8'd8;
            default: r = b;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] single_kind(input mode_t m);
        logic [5:0] k;
        case (m)
            M_PLUS:  k = K_PLUS;
            M_EQ:    k = K_ASSIGN;
            M_OR:    k = K_OR;
            M_AND:   k = K_AND;
            M_GT:    k = K_MORE;
            M_LT:    k = K_LESS;
            M_BANG:  k = K_NOT;
            M_MINUS: k = K_MINUS;
            default: k = K_DIVIDE;
        endcase
        return k;
    endfunction

    function automatic token_t make_tok(input logic [5:0] k, input pos_t p,
                                        input logic [63:0] v, input logic [7:0] c);
        token_t t;
        t.kind = k;
        t.pos = p;
        t.value = v;
        t.text_char = c;
        return t;
    endfunction

endpackage

>>> rtl/core/stok_accum.sv
// Saturating number accumulator step: acc * radix + digit, clamped at 2^63-1.
// Depends on stok_pkg.
`timescale 1ns / 1ps

module stok_accum (
    input  logic [63:0]    acc,
    input  stok_pkg::base_t base,
    input  logic [3:0]     digit,
    output logic [63:0]    acc_next
);

    logic [67:0] wide;

    // Radix multiply is shifts and adds; the top bits flag overflow.
    always_comb begin
        case (base)
            stok_pkg::B_HEX: wide = {acc, 4'b0} + {64'd0, digit};
            stok_pkg::B_BIN: wide = {3'b0, acc, 1'b0} + {64'd0, digit};
            default:         wide = {1'b0, acc, 3'b0} + {3'b0, acc, 1'b0}
                                    + {64'd0, digit};
        endcase
        if (wide > {4'd0, stok_pkg::VALUE_MAX}) begin
            acc_next = stok_pkg::VALUE_MAX;
        end else begin
            acc_next = wide[63:0];
        end
    end

endmodule

>>> rtl/core/stok_scan.sv
// Per-byte scanner: mode state and the combinational token decision.
// Depends on stok_pkg and stok_accum.
`timescale 1ns / 1ps

module stok_scan (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step,
    input  logic [7:0]                b,
    input  logic                      eoi,
    output stok_pkg::result_pair_t    res
);

    stok_pkg::mode_t mode_reg, mode_next;
    stok_pkg::pos_t  cnt_reg, cnt_next, start_reg, start_next;
    logic [63:0]     acc_reg, acc_next;
    stok_pkg::base_t base_reg, base_next;
    logic            stop_reg, stop_next;
    logic [7:0]      lit_reg, lit_next;

    logic [3:0]      digit;
    logic [63:0]     acc_step;
    logic            is_hex_alpha;

    // Digit value of the current byte for the accumulator.
    always_comb begin
        is_hex_alpha = (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
        if (stok_pkg::is_digit(b)) begin
            digit = 4'(b - 8'h30);
        end else if (b >= "a" && b <= "f") begin
            digit = 4'(b - 8'h57);
        end else begin
            digit = 4'(b - 8'h37);
        end
    end

    stok_accum u_accum (
        .acc      (acc_reg),
        .base     (base_reg),
        .digit    (digit),
        .acc_next (acc_step)
    );

    // Next state and results for one input transfer.
    always_comb begin
        logic        do_idle;
        stok_pkg::pos_t pos;
        logic [5:0]  pk;
        stok_pkg::token_t it;
        logic        iv;
        mode_next = mode_reg;
        cnt_next = cnt_reg;
        start_next = start_reg;
        acc_next = acc_reg;
        base_next = base_reg;
        stop_next = stop_reg;
        lit_next = lit_reg;
        res = '0;
        do_idle = 1'b0;
        pos = cnt_reg;
        pk = 6'd0;
        it = '0;
        iv = 1'b0;

        if (eoi) begin
            case (mode_reg)
                stok_pkg::M_NZERO, stok_pkg::M_NUM: begin
                    res.valid0 = 1'b1;
                    res.tok0 = stok_pkg::make_tok(stok_pkg::K_NUMBER, start_reg, acc_reg, 8'd0);
                end
                stok_pkg::M_CH_OPEN, stok_pkg::M_CH_ESC, stok_pkg::M_CH_CLOSE,
                stok_pkg::M_STR, stok_pkg::M_STR_ESC: begin
                    res.valid0 = 1'b1;
                    res.tok0 = stok_pkg::make_tok(stok_pkg::K_QUOTE, start_reg, 64'd0, 8'd0);
                end
                stok_pkg::M_DOT: begin
                    res.valid0 = 1'b1;
                    res.tok0 = stok_pkg::make_tok(stok_pkg::K_LONE_DOT, start_reg, 64'd0,
                                                  8'd0);
                end
                stok_pkg::M_PLUS, stok_pkg::M_EQ, stok_pkg::M_OR, stok_pkg::M_AND,
                stok_pkg::M_GT, stok_pkg::M_LT, stok_pkg::M_BANG, stok_pkg::M_MINUS,
                stok_pkg::M_SLASH: begin
                    res.valid0 = 1'b1;
                    res.tok0 = stok_pkg::make_tok(stok_pkg::single_kind(mode_reg), start_reg,
                                                  64'd0, 8'd0);
                end
                default: ;
            endcase
            res.valid1 = 1'b1;
            res.tok1 = stok_pkg::make_tok(stok_pkg::K_EOF, cnt_reg, 64'd0, 8'd0);
            mode_next = stok_pkg::M_IDLE;
            cnt_next = '0;
            start_next = '0;
            acc_next = '0;
            base_next = stok_pkg::B_DEC;
            stop_next = 1'b0;
            lit_next = '0;
        end else begin
            cnt_next = cnt_reg + 1'b1;
            case (mode_reg)
                stok_pkg::M_IDLE: do_idle = 1'b1;
                stok_pkg::M_IDENT: begin
                    if (stok_pkg::is_alpha(b) || stok_pkg::is_digit(b) || b == "_") begin
                        res.valid1 = 1'b1;
                        res.tok1 = stok_pkg::make_tok(stok_pkg::K_TEXT, start_reg, 64'd0, b);
                    end else begin
                        do_idle = 1'b1;
                    end
                end
                stok_pkg::M_NZERO, stok_pkg::M_NUM: begin
                    if (mode_reg == stok_pkg::M_NZERO && (b == "x" || b == "X")) begin
                        base_next = stok_pkg::B_HEX;
                        mode_next = stok_pkg::M_NUM;
                    end else if (mode_reg == stok_pkg::M_NZERO && (b == "b" || b == "B")) begin
                        base_next = stok_pkg::B_BIN;
                        mode_next = stok_pkg::M_NUM;
                    end else begin
                        mode_next = stok_pkg::M_NUM;
                        if (base_reg == stok_pkg::B_HEX &&
                            (stok_pkg::is_digit(b) || is_hex_alpha)) begin
                            acc_next = acc_step;
                        end else if (base_reg != stok_pkg::B_HEX && stok_pkg::is_digit(b)) begin
                            if (base_reg == stok_pkg::B_DEC) begin
                                acc_next = acc_step;
                            end else if (b > "1") begin
                                stop_next = 1'b1;
                            end else if (!stop_reg) begin
                                acc_next = acc_step;
                            end
                        end else begin
                            res.valid0 = 1'b1;
                            res.tok0 = stok_pkg::make_tok(stok_pkg::K_NUMBER, start_reg,
                                                          acc_reg, 8'd0);
                            do_idle = 1'b1;
                        end
                    end
                end
                stok_pkg::M_CH_OPEN: begin
                    if (b == "\\") begin
                        mode_next = stok_pkg::M_CH_ESC;
                    end else begin
                        lit_next = b;
                        mode_next = stok_pkg::M_CH_CLOSE;
                    end
                end
                stok_pkg::M_CH_ESC: begin
                    lit_next = stok_pkg::unescape(b);
                    mode_next = stok_pkg::M_CH_CLOSE;
                end
                stok_pkg::M_CH_CLOSE: begin
                    if (b != "'") begin
                        res.valid0 = 1'b1;
                        res.tok0 = stok_pkg::make_tok(stok_pkg::K_QUOTE, pos, 64'd0, 8'd0);
                    end
                    res.valid1 = 1'b1;
                    res.tok1 = stok_pkg::make_tok(stok_pkg::K_NUMBER, start_reg,
                                                  {56'd0, lit_reg}, 8'd0);
                    mode_next = stok_pkg::M_IDLE;
                end
                stok_pkg::M_STR: begin
                    if (b == "\"") begin
                        mode_next = stok_pkg::M_IDLE;
                    end else if (b == "\\") begin
                        mode_next = stok_pkg::M_STR_ESC;
                    end else begin
                        res.valid1 = 1'b1;
                        res.tok1 = stok_pkg::make_tok(stok_pkg::K_TEXT, start_reg, 64'd0, b);
                    end
                end
                stok_pkg::M_STR_ESC: begin
                    res.valid1 = 1'b1;
                    res.tok1 = stok_pkg::make_tok(stok_pkg::K_TEXT, start_reg, 64'd0,
                                                  stok_pkg::unescape(b));
                    mode_next = stok_pkg::M_STR;
                end
                stok_pkg::M_LCOMM: begin
                    if (b == 8'd10) mode_next = stok_pkg::M_IDLE;
                end
                stok_pkg::M_BCOMM: begin
                    if (b == "*") mode_next = stok_pkg::M_BSTAR;
                end
                stok_pkg::M_BSTAR: begin
                    if (b == "/") mode_next = stok_pkg::M_IDLE;
                    else if (b != "*") mode_next = stok_pkg::M_BCOMM;
                end
                stok_pkg::M_DOT: begin
                    res.valid1 = 1'b1;
                    res.tok1 = stok_pkg::make_tok(
                        (b == ".") ? stok_pkg::K_RANGE_DOT : stok_pkg::K_LONE_DOT,
                        start_reg, 64'd0, 8'd0);
                    mode_next = stok_pkg::M_IDLE;
                end
                stok_pkg::M_SLASH: begin
                    if (b == "/") begin
                        mode_next = stok_pkg::M_LCOMM;
                    end else if (b == "*") begin
                        mode_next = stok_pkg::M_BCOMM;
                    end else begin
                        res.valid0 = 1'b1;
                        res.tok0 = stok_pkg::make_tok(stok_pkg::K_DIVIDE, start_reg, 64'd0,
                                                      8'd0);
                        do_idle = 1'b1;
                    end
                end
                default: begin
                    // Operators with an optional second character.
                    case (mode_reg)
                        stok_pkg::M_PLUS:  pk = (b == "+") ? stok_pkg::K_INCREASE : 6'd0;
                        stok_pkg::M_EQ:    pk = (b == "=") ? stok_pkg::K_EQUALS : 6'd0;
                        stok_pkg::M_OR:    pk = (b == "|") ? stok_pkg::K_OR : 6'd0;
                        stok_pkg::M_AND:   pk = (b == "&") ? stok_pkg::K_AND : 6'd0;
                        stok_pkg::M_GT:    pk = (b == "=") ? stok_pkg::K_MORE_EQ :
                                                ((b == ">") ? stok_pkg::K_SHR : 6'd0);
                        stok_pkg::M_LT:    pk = (b == "=") ? stok_pkg::K_LESS_EQ :
                                                ((b == "<") ? stok_pkg::K_SHL : 6'd0);
                        stok_pkg::M_BANG:  pk = (b == "=") ? stok_pkg::K_NOT_EQ : 6'd0;
                        stok_pkg::M_MINUS: pk = (b == ">") ? stok_pkg::K_ARROW :
                                                ((b == "-") ? stok_pkg::K_DECREASE : 6'd0);
                        default:           pk = 6'd0;
                    endcase
                    if (pk != 6'd0) begin
                        res.valid1 = 1'b1;
                        res.tok1 = stok_pkg::make_tok(pk, start_reg, 64'd0, 8'd0);
                        mode_next = stok_pkg::M_IDLE;
                    end else begin
                        res.valid0 = 1'b1;
                        res.tok0 = stok_pkg::make_tok(stok_pkg::single_kind(mode_reg),
                                                      start_reg, 64'd0, 8'd0);
                        do_idle = 1'b1;
                    end
                end
            endcase

            // Byte seen between tokens.
            if (do_idle) begin
                mode_next = stok_pkg::M_IDLE;
                start_next = pos;
                if (stok_pkg::is_digit(b)) begin
                    stop_next = 1'b0;
                    base_next = stok_pkg::B_DEC;
                    acc_next = {60'd0, digit};
                    mode_next = (b == "0") ? stok_pkg::M_NZERO : stok_pkg::M_NUM;
                end else if (stok_pkg::is_alpha(b) || b == "_") begin
                    mode_next = stok_pkg::M_IDENT;
                    iv = 1'b1;
                    it = stok_pkg::make_tok(stok_pkg::K_ID, pos, 64'd0, b);
                end else if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
                    iv = 1'b0;
                end else begin
                    iv = 1'b1;
                    it = stok_pkg::make_tok(stok_pkg::K_ILLEGAL, pos, 64'd0, 8'd0);
                    case (b)
                        "'": begin iv = 1'b0; mode_next = stok_pkg::M_CH_OPEN; end
                        "\"": begin
                            mode_next = stok_pkg::M_STR;
                            it.kind = stok_pkg::K_STRING;
                        end
                        "(": it.kind = stok_pkg::K_LPAREN;
                        ")": it.kind = stok_pkg::K_RPAREN;
                        "{": it.kind = stok_pkg::K_LBRACE;
                        "}": it.kind = stok_pkg::K_RBRACE;
                        "[": it.kind = stok_pkg::K_LBRACKET;
                        "]": it.kind = stok_pkg::K_RBRACKET;
                        ",": it.kind = stok_pkg::K_COMMA;
                        "*": it.kind = stok_pkg::K_MULTIPLY;
                        "%": it.kind = stok_pkg::K_MODULO;
                        "^": it.kind = stok_pkg::K_XOR;
                        "~": it.kind = stok_pkg::K_BIT_NOT;
                        ";": it.kind = stok_pkg::K_EOL;
                        "+": begin iv = 1'b0; mode_next = stok_pkg::M_PLUS; end
                        "=": begin iv = 1'b0; mode_next = stok_pkg::M_EQ; end
                        "|": begin iv = 1'b0; mode_next = stok_pkg::M_OR; end
                        "&": begin iv = 1'b0; mode_next = stok_pkg::M_AND; end
                        ">": begin iv = 1'b0; mode_next = stok_pkg::M_GT; end
                        "<": begin iv = 1'b0; mode_next = stok_pkg::M_LT; end
                        "!": begin iv = 1'b0; mode_next = stok_pkg::M_BANG; end
                        "-": begin iv = 1'b0; mode_next = stok_pkg::M_MINUS; end
                        "/": begin iv = 1'b0; mode_next = stok_pkg::M_SLASH; end
                        ".": begin iv = 1'b0; mode_next = stok_pkg::M_DOT; end
                        default: ;
                    endcase
                end
                res.valid1 = iv;
                res.tok1 = it;
            end
        end
    end

    // State registers, advanced once per input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= stok_pkg::M_IDLE;
            cnt_reg   <= '0;
            start_reg <= '0;
            acc_reg   <= '0;
            base_reg  <= stok_pkg::B_DEC;
            stop_reg  <= 1'b0;
            lit_reg   <= '0;
        end else if (step) begin
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            start_reg <= start_next;
            acc_reg   <= acc_next;
            base_reg  <= base_next;
            stop_reg  <= stop_next;
            lit_reg   <= lit_next;
        end
    end

    // End of input clears the scanner, each byte advances the counter and
    // the accumulator never passes the saturation value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && eoi) |=> (mode_reg == stok_pkg::M_IDLE && cnt_reg == '0))
        else $error("end of input did not return scanner to reset");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !eoi) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("byte counter did not advance");
    assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg <= stok_pkg::VALUE_MAX)
        else $error("accumulator exceeded saturation value");

endmodule

>>> rtl/core/source_tokenizer.sv
// Top level of the source tokenizer: input register, scanner, result queue.
// Depends on stok_pkg and stok_scan.
//
//  channel | dir | tdata (low bit up)                   | tuser
//  s_      | in  | text_byte[7:0]                       | end_of_input
//  m_      | out | token_kind[5:0], start_position[29:6],| -
//          |     | number_value[93:30], text_char[101:94]; tlast = last_of_run
//
// Up to one byte per cycle is accepted while the result queue has room; a byte gives zero, one or two results.
// The scanner runs as a byte leaves the input register; its one or two results
// go into a two-entry result register, drained one per cycle while m_tready is
// high, so a result is offered from that register once its byte has been scanned.
// A byte with two results holds the input while they drain.
// Input is taken whenever the input stage is empty or moves on this cycle.
// Reset (aresetn low, synchronous) empties both stages and clears scan state.
`timescale 1ns / 1ps

module source_tokenizer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // text_byte
    input  logic         s_tuser,   // end_of_input
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // token_kind, start_position, number_value, text_char
    output logic         m_tlast    // last_of_run
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;

    stok_pkg::result_pair_t res;
    stok_pkg::token_t       q_tok_reg [2];
    logic                   q_last_reg [2];
    logic [1:0]             q_cnt_reg, q_cnt_next;
    logic                   step, q_pop;
    logic                   q_room;

    // The queue must be able to take the worst case after this cycle's pop.
    assign q_pop  = m_tvalid && m_tready;
    assign q_room = (q_cnt_reg == 2'd0) || (q_cnt_reg == 2'd1 && q_pop);
    assign step   = in_valid_reg && q_room;
    assign s_tready = !in_valid_reg || step;
    assign in_valid_next = (s_tvalid && s_tready) ? 1'b1 : (step ? 1'b0 : in_valid_reg);

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eoi_reg  <= s_tuser;
        end
    end

    stok_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .b       (in_byte_reg),
        .eoi     (in_eoi_reg),
        .res     (res)
    );

    // Result queue: entry 0 is the head.
    always_comb begin
        logic [1:0] after_pop;
        after_pop  = q_cnt_reg - {1'b0, q_pop};
        q_cnt_next = after_pop;
        if (step) begin
            q_cnt_next = after_pop + {1'b0, res.valid0} + {1'b0, res.valid1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_cnt_reg <= 2'd0;
        end else begin
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            // Queue is empty after the pop, so load fresh results at the head.
            if (res.valid0) begin
                q_tok_reg[0]  <= res.tok0;
                q_last_reg[0] <= !res.valid1;
                q_tok_reg[1]  <= res.tok1;
                q_last_reg[1] <= 1'b1;
            end else begin
                q_tok_reg[0]  <= res.tok1;
                q_last_reg[0] <= 1'b1;
            end
        end else if (q_pop) begin
            q_tok_reg[0]  <= q_tok_reg[1];
            q_last_reg[0] <= q_last_reg[1];
        end
    end

    assign m_tvalid = q_cnt_reg != 2'd0;
    assign m_tlast  = q_last_reg[0];
    assign m_tdata  = {2'b00, q_tok_reg[0].text_char, q_tok_reg[0].value,
                       q_tok_reg[0].pos, q_tok_reg[0].kind};

    assert property (@(posedge aclk) disable iff (!aresetn) q_cnt_reg != 2'd3)
        else $error("result queue overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        step |-> (q_cnt_reg == 2'd0 || q_pop))
        else $error("scanner stepped without queue room");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_cnt_reg == 2'd2) |-> !q_last_reg[0])
        else $error("two queued results but head marked last");

endmodule

>>> dv/tb_source_tokenizer.sv
// Testbench for source_tokenizer: drives text bytes and end-of-input markers,
// predicts the token stream in a local scanner model and checks each result.
// Depends on stok_pkg and the source_tokenizer RTL.
`timescale 1ns / 1ps

module tb_source_tokenizer;

    typedef struct {
        logic [5:0]  kind;
        logic [23:0] pos;
        logic [63:0] value;
        logic [7:0]  tchar;
        logic        last;
    } tok_exp_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         m_tlast;

    source_tokenizer u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    // Scanner copy used for prediction.
    stok_pkg::mode_t lx_mode = stok_pkg::M_IDLE;
    logic [23:0]     lx_count = '0;
    logic [23:0]     lx_start = '0;
    logic [63:0]     lx_acc = '0;
    stok_pkg::base_t lx_base = stok_pkg::B_DEC;
    logic            lx_bstop = 1'b0;
    logic [7:0]      lx_lit = '0;

    tok_exp_t token_queue[$];
    int       run_tokens;
    int       errors = 0;
    bit       gap_enable = 1'b1;
    bit       hold_sink = 1'b0;

    function automatic bit digit_c(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit alpha_c(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic [7:0] escape_map(input logic [7:0] b);
        case (b)
            "n": return 8'd10;
            "r": return 8'd13;
            "t": return 8'd9;
            "b": return 8'd8;
            default: return b;
        endcase
    endfunction

    function automatic logic [5:0] lone_op(input stok_pkg::mode_t m);
        case (m)
            stok_pkg::M_PLUS: return stok_pkg::K_PLUS;
            stok_pkg::M_EQ: return stok_pkg::K_ASSIGN;
            stok_pkg::M_OR: return stok_pkg::K_OR;
            stok_pkg::M_AND: return stok_pkg::K_AND;
            stok_pkg::M_GT: return stok_pkg::K_MORE;
            stok_pkg::M_LT: return stok_pkg::K_LESS;
            stok_pkg::M_BANG: return stok_pkg::K_NOT;
            stok_pkg::M_MINUS: return stok_pkg::K_MINUS;
            default: return stok_pkg::K_DIVIDE;
        endcase
    endfunction

    function automatic logic [5:0] pair_op(input stok_pkg::mode_t m, input logic [7:0] b);
        case (m)
            stok_pkg::M_PLUS: return b == "+" ? stok_pkg::K_INCREASE : 6'd0;
            stok_pkg::M_EQ: return b == "=" ? stok_pkg::K_EQUALS : 6'd0;
            stok_pkg::M_OR: return b == "|" ? stok_pkg::K_OR : 6'd0;
            stok_pkg::M_AND: return b == "&" ? stok_pkg::K_AND : 6'd0;
            stok_pkg::M_GT:
                return b == "=" ? stok_pkg::K_MORE_EQ : (b == ">" ? stok_pkg::K_SHR : 6'd0);
            stok_pkg::M_LT:
                return b == "=" ? stok_pkg::K_LESS_EQ : (b == "<" ? stok_pkg::K_SHL : 6'd0);
            stok_pkg::M_BANG: return b == "=" ? stok_pkg::K_NOT_EQ : 6'd0;
            stok_pkg::M_MINUS:
                return b == ">" ? stok_pkg::K_ARROW : (b == "-" ? stok_pkg::K_DECREASE : 6'd0);
            default: return 6'd0;
        endcase
    endfunction

    task automatic push_token(input logic [5:0] k, input logic [23:0] p,
                              input logic [63:0] v, input logic [7:0] c);
        tok_exp_t t;
        t.kind = k; t.pos = p; t.value = v; t.tchar = c; t.last = 1'b0;
        token_queue.push_back(t);
        run_tokens++;
    endtask

    // Saturating multiply-add into the number accumulator.
    task automatic acc_digit(input logic [63:0] radix, input logic [63:0] d);
        if (lx_acc > (stok_pkg::VALUE_MAX - d) / radix) lx_acc = stok_pkg::VALUE_MAX;
        else lx_acc = lx_acc * radix + d;
    endtask

    task automatic scan_fresh(input logic [7:0] b, input logic [23:0] p);
        lx_mode = stok_pkg::M_IDLE;
        lx_start = p;
        if (digit_c(b)) begin
            lx_bstop = 1'b0;
            lx_base = stok_pkg::B_DEC;
            lx_acc = 64'(b - "0");
            lx_mode = (b == "0") ? stok_pkg::M_NZERO : stok_pkg::M_NUM;
        end else if (alpha_c(b) || b == "_") begin
            lx_mode = stok_pkg::M_IDENT;
            push_token(stok_pkg::K_ID, p, 0, b);
        end else if (b == " " || (b >= 9 && b <= 13)) begin
        end else begin
            case (b)
                "'": lx_mode = stok_pkg::M_CH_OPEN;
                "\"": begin
                    lx_mode = stok_pkg::M_STR;
                    push_token(stok_pkg::K_STRING, p, 0, 0);
                end
                "(": push_token(stok_pkg::K_LPAREN, p, 0, 0);
                ")": push_token(stok_pkg::K_RPAREN, p, 0, 0);
                "{": push_token(stok_pkg::K_LBRACE, p, 0, 0);
                "}": push_token(stok_pkg::K_RBRACE, p, 0, 0);
                "[": push_token(stok_pkg::K_LBRACKET, p, 0, 0);
                "]": push_token(stok_pkg::K_RBRACKET, p, 0, 0);
                ",": push_token(stok_pkg::K_COMMA, p, 0, 0);
                "*": push_token(stok_pkg::K_MULTIPLY, p, 0, 0);
                "%": push_token(stok_pkg::K_MODULO, p, 0, 0);
                "^": push_token(stok_pkg::K_XOR, p, 0, 0);
                "~": push_token(stok_pkg::K_BIT_NOT, p, 0, 0);
                ";": push_token(stok_pkg::K_EOL, p, 0, 0);
                "+": lx_mode = stok_pkg::M_PLUS;
                "=": lx_mode = stok_pkg::M_EQ;
                "|": lx_mode = stok_pkg::M_OR;
                "&": lx_mode = stok_pkg::M_AND;
                ">": lx_mode = stok_pkg::M_GT;
                "<": lx_mode = stok_pkg::M_LT;
                "!": lx_mode = stok_pkg::M_BANG;
                "-": lx_mode = stok_pkg::M_MINUS;
                "/": lx_mode = stok_pkg::M_SLASH;
                ".": lx_mode = stok_pkg::M_DOT;
                default: push_token(stok_pkg::K_ILLEGAL, p, 0, 0);
            endcase
        end
    endtask

    task automatic scan_number(input logic [7:0] b, input logic [23:0] p);
        if (lx_base == stok_pkg::B_HEX && digit_c(b)) acc_digit(16, 64'(b - "0"));
        else if (lx_base == stok_pkg::B_HEX && b >= "a" && b <= "f")
            acc_digit(16, 64'(b - "a" + 10));
        else if (lx_base == stok_pkg::B_HEX && b >= "A" && b <= "F")
            acc_digit(16, 64'(b - "A" + 10));
        else if (lx_base != stok_pkg::B_HEX && digit_c(b)) begin
            if (lx_base == stok_pkg::B_DEC) acc_digit(10, 64'(b - "0"));
            else if (b > "1") lx_bstop = 1'b1;
            else if (!lx_bstop) acc_digit(2, 64'(b - "0"));
        end else begin
            push_token(stok_pkg::K_NUMBER, lx_start, lx_acc, 0);
            scan_fresh(b, p);
        end
    endtask

    // Predicts the tokens caused by one input transfer.
    task automatic predict_tokens(input logic [7:0] b, input logic eoi);
        logic [23:0] p;
        logic [5:0]  k;
        run_tokens = 0;
        if (eoi) begin
            case (lx_mode)
                stok_pkg::M_NZERO, stok_pkg::M_NUM:
                    push_token(stok_pkg::K_NUMBER, lx_start, lx_acc, 0);
                stok_pkg::M_CH_OPEN, stok_pkg::M_CH_ESC, stok_pkg::M_CH_CLOSE,
                stok_pkg::M_STR, stok_pkg::M_STR_ESC:
                    push_token(stok_pkg::K_QUOTE, lx_start, 0, 0);
                stok_pkg::M_DOT: push_token(stok_pkg::K_LONE_DOT, lx_start, 0, 0);
                default:
                    if (lx_mode >= stok_pkg::M_PLUS)
                        push_token(lone_op(lx_mode), lx_start, 0, 0);
            endcase
            push_token(stok_pkg::K_EOF, lx_count, 0, 0);
            lx_mode = stok_pkg::M_IDLE; lx_count = '0; lx_start = '0; lx_acc = '0;
            lx_base = stok_pkg::B_DEC; lx_bstop = 1'b0; lx_lit = '0;
        end else begin
            p = lx_count;
            lx_count = lx_count + 1'b1;
            case (lx_mode)
                stok_pkg::M_IDLE: scan_fresh(b, p);
                stok_pkg::M_IDENT:
                    if (alpha_c(b) || digit_c(b) || b == "_")
                        push_token(stok_pkg::K_TEXT, lx_start, 0, b);
                    else scan_fresh(b, p);
                stok_pkg::M_NZERO:
                    if (b == "x" || b == "X") begin
                        lx_base = stok_pkg::B_HEX; lx_mode = stok_pkg::M_NUM;
                    end else if (b == "b" || b == "B") begin
                        lx_base = stok_pkg::B_BIN; lx_mode = stok_pkg::M_NUM;
                    end else begin
                        lx_mode = stok_pkg::M_NUM; scan_number(b, p);
                    end
                stok_pkg::M_NUM: scan_number(b, p);
                stok_pkg::M_CH_OPEN:
                    if (b == "\\") lx_mode = stok_pkg::M_CH_ESC;
                    else begin lx_lit = b; lx_mode = stok_pkg::M_CH_CLOSE; end
                stok_pkg::M_CH_ESC: begin
                    lx_lit = escape_map(b); lx_mode = stok_pkg::M_CH_CLOSE;
                end
                stok_pkg::M_CH_CLOSE: begin
                    if (b != "'") push_token(stok_pkg::K_QUOTE, p, 0, 0);
                    push_token(stok_pkg::K_NUMBER, lx_start, 64'(lx_lit), 0);
                    lx_mode = stok_pkg::M_IDLE;
                end
                stok_pkg::M_STR:
                    if (b == "\"") lx_mode = stok_pkg::M_IDLE;
                    else if (b == "\\") lx_mode = stok_pkg::M_STR_ESC;
                    else push_token(stok_pkg::K_TEXT, lx_start, 0, b);
                stok_pkg::M_STR_ESC: begin
                    push_token(stok_pkg::K_TEXT, lx_start, 0, escape_map(b));
                    lx_mode = stok_pkg::M_STR;
                end
                stok_pkg::M_LCOMM: if (b == "\n") lx_mode = stok_pkg::M_IDLE;
                stok_pkg::M_BCOMM: if (b == "*") lx_mode = stok_pkg::M_BSTAR;
                stok_pkg::M_BSTAR:
                    if (b == "/") lx_mode = stok_pkg::M_IDLE;
                    else if (b != "*") lx_mode = stok_pkg::M_BCOMM;
                stok_pkg::M_DOT: begin
                    push_token(b == "." ? stok_pkg::K_RANGE_DOT : stok_pkg::K_LONE_DOT,
                               lx_start, 0, 0);
                    lx_mode = stok_pkg::M_IDLE;
                end
                stok_pkg::M_SLASH:
                    if (b == "/") lx_mode = stok_pkg::M_LCOMM;
                    else if (b == "*") lx_mode = stok_pkg::M_BCOMM;
                    else begin
                        push_token(stok_pkg::K_DIVIDE, lx_start, 0, 0);
                        scan_fresh(b, p);
                    end
                default: begin
                    k = pair_op(lx_mode, b);
                    if (k != 0) begin
                        push_token(k, lx_start, 0, 0);
                        lx_mode = stok_pkg::M_IDLE;
                    end else begin
                        push_token(lone_op(lx_mode), lx_start, 0, 0);
                        scan_fresh(b, p);
                    end
                end
            endcase
        end
        if (run_tokens > 0) token_queue[$].last = 1'b1;
    endtask

    // Sends one item; waits for the transfer, then predicts its tokens.
    task automatic send_item(input logic [7:0] b, input logic eoi);
        while (gap_enable && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_tokens(b, eoi);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    task automatic end_text();
        send_item(8'd0, 1'b1);
    endtask

    task automatic drain_tokens();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (token_queue.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    // Receiver: random stalls, with a long hold when asked.
    always @(posedge aclk) begin
        if (!aresetn || hold_sink) m_tready <= 1'b0;
        else m_tready <= !(gap_enable && $urandom_range(99) < 9);
    end

    // Checks each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        tok_exp_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (token_queue.size() == 0) begin
                $display("%0t: unexpected result tdata=%h last=%b", $time, m_tdata, m_tlast);
                errors++;
            end else begin
                e = token_queue.pop_front();
                if (m_tdata[5:0] !== e.kind) begin
                    $display("%0t: kind exp %0d got %0d", $time, e.kind, m_tdata[5:0]);
                    errors++;
                end
                if (m_tdata[29:6] !== e.pos) begin
                    $display("%0t: position exp %0d got %0d", $time, e.pos, m_tdata[29:6]);
                    errors++;
                end
                if (m_tdata[93:30] !== e.value) begin
                    $display("%0t: value exp %h got %h", $time, e.value, m_tdata[93:30]);
                    errors++;
                end
                if (m_tdata[101:94] !== e.tchar) begin
                    $display("%0t: char exp %h got %h", $time, e.tchar, m_tdata[101:94]);
                    errors++;
                end
                if (m_tdata[103:102] !== 2'b00) begin
                    $display("%0t: pad exp 0 got %b", $time, m_tdata[103:102]);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $display("%0t: last exp %b got %b", $time, e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic test_operators();
        send_text("()[]{},*%^~;+ ++= ==| ||& &&> >= >>< <= <<! !=- -> --/ a");
        send_text("..x.;\x01\x00\xff\x80 `$@");
        end_text();
        send_text("+");
        end_text();
        send_text(".");
        end_text();
        drain_tokens();
    endtask

    task automatic test_numbers();
        send_text("0 7 0x1fAz 0XFF 0b1012 0B11 9223372036854775807 99999999999999999999 ");
        send_text("0xffffffffffffffffff 0b");
        end_text();
        send_text("123");
        end_text();
        drain_tokens();
    endtask

    task automatic test_text();
        send_text("ab_9 _x \"hi\\n\\t\\r\\b\\q\" 'a' '\\n' 'xy '\\'' /* c ** */ // l\nz");
        send_text("\"open");
        end_text();
        send_text("'q");
        end_text();
        send_text("/* open");
        end_text();
        send_text("// open");
        end_text();
        end_text();
        drain_tokens();
    endtask

    // Back-pressure: receiver holds off while the sender keeps going.
    task automatic test_backpressure();
        hold_sink = 1'b1;
        fork
            send_text("(((((((())))))))a+b;");
            begin
                int n = 0;
                while (n < 200) begin
                    @(posedge aclk);
                    n++;
                end
                hold_sink = 1'b0;
            end
        join
        end_text();
        drain_tokens();
    endtask

    // Mostly well-formed token sequences with random content, plus noise.
    task automatic test_random();
        string pieces[] = '{"(", ")", "{", "}", "[", "]", ",", "+", "++", "-", "--", "->",
            "*", "/", "%", "=", "==", "!", "!=", "<", "<=", "<<", ">", ">=", ">>",
            "&", "&&", "|", "||", "^", "~", ";", "..", "foo", "x_1", "0", "0x", "0b",
            "'a'", "'\\t'", "\"s\\\"t\"", "/*k*/", "//c\n", " ", "\n", "."};
        int sent = 0;
        logic [7:0] c;
        while (sent < 800) begin
            gap_enable = !(sent >= 400 && sent < 550);
            case ($urandom_range(9))
                0, 1: begin
                    send_item(8'($urandom), 1'b0);
                    sent++;
                end
                2: begin
                    for (int i = $urandom_range(1, 20); i > 0; i--) begin
                        c = "0" + 8'($urandom_range(9));
                        if ($urandom_range(3) == 0) c = "a" + 8'($urandom_range(5));
                        send_item(c, 1'b0);
                        sent++;
                    end
                end
                3: if ($urandom_range(7) == 0) begin
                    end_text();
                    sent++;
                end
                default: begin
                    send_text(pieces[$urandom_range(pieces.size() - 1)]);
                    sent += 2;
                end
            endcase
            if (sent % 300 == 0) drain_tokens();
        end
        gap_enable = 1'b1;
        end_text();
        drain_tokens();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_operators();
        test_numbers();
        test_text();
        test_backpressure();
        test_random();
        repeat (20) @(posedge aclk);
        if (errors == 0 && token_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
